// ===== hdl/bdpc_pkg.sv =====
`default_nettype none
package bdpc_pkg;

  localparam int BTN_NUM   = 5;
  localparam int IDX_OFF   = 0;
  localparam int IDX_S1    = 1;
  localparam int IDX_S2    = 2;
  localparam int IDX_S3    = 3;
  localparam int IDX_LIGHT = 4;

  localparam int RAW_TIME_W = 32;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 8'd1;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd30;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd3000;

  typedef struct packed {
    logic short_evt;
    logic long_evt;
  } press_evt_t;

endpackage
`default_nettype wire

// ===== hdl/bdpc_debounce_lane.sv =====
`default_nettype none
module bdpc_debounce_lane
  import bdpc_pkg::*;
#(
  parameter int TIME_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  raw,
  input  wire logic [TIME_WIDTH-1:0] now,
  input  wire logic [CFG_W-1:0]      debounce_time,
  output logic                       stable
);

  logic                  last_raw_r;
  logic                  stable_r;
  logic                  stable_nxt;
  logic [TIME_WIDTH-1:0] change_time_r;
  logic [TIME_WIDTH-1:0] change_time_nxt;
  logic [TIME_WIDTH-1:0] elapsed;

  always_comb begin
    change_time_nxt = (raw != last_raw_r) ? now : change_time_r;
    elapsed         = now - change_time_nxt;
    stable_nxt      = stable_r;
    if (elapsed >= TIME_WIDTH'(debounce_time)) begin
      stable_nxt = raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r    <= 1'b0;
      stable_r      <= 1'b0;
      change_time_r <= '0;
    end else if (en) begin
      last_raw_r    <= raw;
      stable_r      <= stable_nxt;
      change_time_r <= change_time_nxt;
    end
  end

  assign stable = stable_r;

endmodule
`default_nettype wire

// ===== hdl/bdpc_priority_filter.sv =====
`default_nettype none
module bdpc_priority_filter
  import bdpc_pkg::*;
(
  input  wire logic [BTN_NUM-1:0] stable,
  output logic      [BTN_NUM-1:0] filt
);

  logic overlap;

  always_comb begin
    overlap = (stable[IDX_S1] & stable[IDX_S2]) | (stable[IDX_S1] & stable[IDX_S3]) |
              (stable[IDX_S2] & stable[IDX_S3]);
    filt            = '0;
    filt[IDX_LIGHT] = stable[IDX_LIGHT];
    if (stable[IDX_OFF]) begin
      filt[IDX_OFF] = 1'b1;
    end else if (!overlap) begin
      filt[IDX_S1] = stable[IDX_S1];
      filt[IDX_S2] = stable[IDX_S2];
      filt[IDX_S3] = stable[IDX_S3];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bdpc_press_lane.sv =====
`default_nettype none
module bdpc_press_lane
  import bdpc_pkg::*;
#(
  parameter int TIME_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  cur,
  input  wire logic [TIME_WIDTH-1:0] now,
  input  wire logic [CFG_W-1:0]      long_press_time,
  output press_evt_t                 evt
);

  logic                  prev_r;
  logic                  fired_r;
  logic                  fired_nxt;
  logic [TIME_WIDTH-1:0] start_r;
  logic [TIME_WIDTH-1:0] start_nxt;
  logic [TIME_WIDTH-1:0] held;

  always_comb begin
    start_nxt = start_r;
    fired_nxt = fired_r;
    if (cur && !prev_r) begin
      start_nxt = now;
      fired_nxt = 1'b0;
    end
    held          = now - start_nxt;
    evt.short_evt = 1'b0;
    evt.long_evt  = 1'b0;
    if (cur) begin
      if (!fired_nxt && held >= TIME_WIDTH'(long_press_time)) begin
        fired_nxt    = 1'b1;
        evt.long_evt = 1'b1;
      end
    end else if (prev_r && !fired_r) begin
      evt.short_evt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= 1'b0;
      fired_r <= 1'b0;
      start_r <= '0;
    end else if (en) begin
      prev_r  <= cur;
      fired_r <= fired_nxt;
      start_r <= start_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/button_debounce_press_classifier.sv =====
// Accepted inputs pass the debounce lane registers, then the output register.
// Throughput: one transaction per cycle unless out_tready stalls; stage 1 is
// the five debounce lanes, stage 2 the priority filter and five press lanes.
// Reset (rst_n low, synchronous): all button state cleared, debounce 30 ms,
// long press 3000 ms, pipeline emptied.
`default_nettype none
module button_debounce_press_classifier
  import bdpc_pkg::*;
#(
  parameter int TIME_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // off, speed_one, speed_two, speed_three, light (1 each), now_ms (32), pad
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // off_short, off_long, speed_one_click, speed_two_click,
  // speed_three_click, light_short, light_long, pad
  output logic      [OUT_DATA_W-1:0] out_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data
);

  logic [CFG_W-1:0]      debounce_r;
  logic [CFG_W-1:0]      long_press_r;
  logic                  adv;
  logic                  in_acc;
  logic                  s1_valid_r;
  logic [TIME_WIDTH-1:0] s1_now_r;
  logic [TIME_WIDTH-1:0] now;
  logic [RAW_TIME_W-1:0] now_raw;
  logic [BTN_NUM-1:0]    stable;
  logic [BTN_NUM-1:0]    filt;
  press_evt_t            evt [BTN_NUM];
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] out_data_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RST;
      long_press_r <= LONG_PRESS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEBOUNCE:   debounce_r   <= cfg_data;
        REG_LONG_PRESS: long_press_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign in_acc    = in_tvalid && adv;

  assign now_raw = in_tdata[BTN_NUM +: RAW_TIME_W];

  generate
    if (TIME_WIDTH > RAW_TIME_W) begin : g_now_wide
      assign now = {{(TIME_WIDTH-RAW_TIME_W){1'b0}}, now_raw};
    end else begin : g_now_narrow
      assign now = now_raw[TIME_WIDTH-1:0];
    end
  endgenerate

  for (genvar i = 0; i < BTN_NUM; i++) begin : g_deb
    bdpc_debounce_lane #(.TIME_WIDTH(TIME_WIDTH)) u_deb (
      .clk           (clk),
      .rst_n         (rst_n),
      .en            (in_acc),
      .raw           (in_tdata[i]),
      .now           (now),
      .debounce_time (debounce_r),
      .stable        (stable[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_now_r <= now;
    end
  end

  bdpc_priority_filter u_filt (
    .stable (stable),
    .filt   (filt)
  );

  for (genvar i = 0; i < BTN_NUM; i++) begin : g_press
    bdpc_press_lane #(.TIME_WIDTH(TIME_WIDTH)) u_press (
      .clk             (clk),
      .rst_n           (rst_n),
      .en              (adv && s1_valid_r),
      .cur             (filt[i]),
      .now             (s1_now_r),
      .long_press_time (long_press_r),
      .evt             (evt[i])
    );
  end

  assign out_data_nxt = {1'b0,
                         evt[IDX_LIGHT].long_evt,
                         evt[IDX_LIGHT].short_evt,
                         evt[IDX_S3].short_evt,
                         evt[IDX_S2].short_evt,
                         evt[IDX_S1].short_evt,
                         evt[IDX_OFF].long_evt,
                         evt[IDX_OFF].short_evt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire
